// ----- design/edsc_pkg.sv -----
// Shared types and constants for the encoder drive-straight controller.
`timescale 1ns / 1ps

package edsc_pkg;

    localparam logic [1:0] KIND_LEFT  = 2'd0;
    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    localparam logic [1:0] DRV_OFF  = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_BACK = 2'd2;

    localparam logic [1:0] CTR_OFF   = 2'd0;
    localparam logic [1:0] CTR_LEFT  = 2'd1;
    localparam logic [1:0] CTR_RIGHT = 2'd2;

    localparam logic [1:0] MODE_STILL = 2'd0;
    localparam logic [1:0] MODE_FWD   = 2'd1;
    localparam logic [1:0] MODE_BACK  = 2'd2;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_B  = 8'h42;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam logic [CFG_IDX_BITS-1:0]  CFG_ACTIVATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0]  CFG_RELEASE  = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0] ACTIVATE_RESET = 10'd38;
    localparam logic [CFG_DATA_BITS-1:0] RELEASE_RESET  = 10'd24;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LEFT_UP,
        ACT_LEFT_DOWN,
        ACT_RIGHT_UP,
        ACT_RIGHT_DOWN,
        ACT_GO_FWD,
        ACT_GO_BACK,
        ACT_LEFT_FWD,
        ACT_LEFT_BACK,
        ACT_RIGHT_FWD,
        ACT_RIGHT_BACK,
        ACT_HALT,
        ACT_CTR_LEFT,
        ACT_CTR_RIGHT,
        ACT_ALL_OFF
    } t_action;

    typedef struct packed {
        logic    valid;
        t_action action;
    } t_qitem;

endpackage

// ----- design/edsc_in_if.sv -----
// Input channel: encoder edges and command bytes.
`timescale 1ns / 1ps

interface edsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       direction_level;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output direction_level, output rx_byte,
                    input ready);
    modport sink (input valid, input kind, input direction_level, input rx_byte,
                  output ready);
endinterface

// ----- design/edsc_out_if.sv -----
// Output channel: drive states and tick counts.
`timescale 1ns / 1ps

interface edsc_out_if #(
    parameter int TICK_BITS = 24
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  left_drive;
    logic [1:0]                  right_drive;
    logic [1:0]                  center_drive;
    logic                        correcting_now;
    logic [1:0]                  side_stopped;
    logic signed [TICK_BITS-1:0] left_count;
    logic signed [TICK_BITS-1:0] right_count;

    modport source (output valid, output left_drive, output right_drive,
                    output center_drive, output correcting_now, output side_stopped,
                    output left_count, output right_count, input ready);
    modport sink (input valid, input left_drive, input right_drive,
                  input center_drive, input correcting_now, input side_stopped,
                  input left_count, input right_count, output ready);
endinterface

// ----- design/encoder_drive_straight_control.sv -----
// Top level of the encoder drive-straight controller.
//
//   channel   dir   handshake        payload
//   i_in      in    valid / ready    kind, direction_level, rx_byte
//   o_out     out   valid / ready    drives, correction status, tick counts
//   i_cfg_*   in    write enable     register index, 10-bit data
//
// One item per cycle sustained while the output is not stalled. Each decoded
// action is written into the two-entry queue when its item is transferred, and
// the counter and check step then loads the result register from its head.
// The count/compare step in the back end sets the clock. Reset loads counters to
// zero, drives off, thresholds 38 and 24.
// A stalled output holds the back end; the queue then fills and drops i_in.ready.
`timescale 1ns / 1ps

module encoder_drive_straight_control #(
    parameter int TICK_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [edsc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [edsc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    edsc_in_if.sink                            i_in,
    edsc_out_if.source                         o_out
);

    edsc_pkg::t_qitem push, head;
    logic             q_ready;
    logic             pop;

    edsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (i_in),
        .i_q_ready (q_ready),
        .o_push    (push)
    );

    edsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_head  (head),
        .i_pop   (pop)
    );

    edsc_back #(
        .TICK_BITS (TICK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .out_ch      (o_out)
    );

endmodule

// ----- design/edsc_front.sv -----
// Front end: accepts items, gathers command bytes and decodes them into actions.
`timescale 1ns / 1ps

module edsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    edsc_in_if.sink          in_ch,
    input  logic             i_q_ready,
    output edsc_pkg::t_qitem o_push
);

    logic [7:0] r_byte0, r_byte1, r_byte2;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       accept;
    edsc_pkg::t_action n_action;

    function automatic edsc_pkg::t_action decode(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
        edsc_pkg::t_action act;
        act = edsc_pkg::ACT_NONE;
        if (a == edsc_pkg::CH_M) begin
            if (b == edsc_pkg::CH_F) begin
                if (c == edsc_pkg::CH_B)      act = edsc_pkg::ACT_GO_FWD;
                else if (c == edsc_pkg::CH_L) act = edsc_pkg::ACT_LEFT_FWD;
                else if (c == edsc_pkg::CH_R) act = edsc_pkg::ACT_RIGHT_FWD;
                else if (c == edsc_pkg::CH_F) act = edsc_pkg::ACT_HALT;
            end else if (b == edsc_pkg::CH_B) begin
                if (c == edsc_pkg::CH_B)      act = edsc_pkg::ACT_GO_BACK;
                else if (c == edsc_pkg::CH_L) act = edsc_pkg::ACT_LEFT_BACK;
                else if (c == edsc_pkg::CH_R) act = edsc_pkg::ACT_RIGHT_BACK;
                else if (c == edsc_pkg::CH_F) act = edsc_pkg::ACT_HALT;
            end else if (b == edsc_pkg::CH_S) begin
                if (c == edsc_pkg::CH_L)      act = edsc_pkg::ACT_CTR_LEFT;
                else if (c == edsc_pkg::CH_R) act = edsc_pkg::ACT_CTR_RIGHT;
                else if (c == edsc_pkg::CH_F) act = edsc_pkg::ACT_ALL_OFF;
            end
        end
        return act;
    endfunction

    assign in_ch.ready = i_q_ready;
    assign accept      = in_ch.valid && i_q_ready;

    always_comb begin
        n_action = edsc_pkg::ACT_NONE;
        n_count  = r_count;
        case (in_ch.kind)
            edsc_pkg::KIND_LEFT: begin
                n_action = in_ch.direction_level ? edsc_pkg::ACT_LEFT_UP
                                                 : edsc_pkg::ACT_LEFT_DOWN;
            end
            edsc_pkg::KIND_RIGHT: begin
                n_action = in_ch.direction_level ? edsc_pkg::ACT_RIGHT_UP
                                                 : edsc_pkg::ACT_RIGHT_DOWN;
            end
            edsc_pkg::KIND_BYTE: begin
                if (in_ch.rx_byte == edsc_pkg::CH_NL) begin
                    if (r_count == 2'd3) n_action = decode(r_byte0, r_byte1, r_byte2);
                    n_count = 2'd0;
                end else if (r_count != 2'd3) begin
                    n_count = r_count + 2'd1;
                end
            end
            default: begin
                n_action = edsc_pkg::ACT_NONE;
            end
        endcase
    end

    assign o_push.valid  = accept;
    assign o_push.action = n_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // byte slots are only read once all three have been written
    always_ff @(posedge i_clk) begin
        if (accept && in_ch.kind == edsc_pkg::KIND_BYTE && in_ch.rx_byte != edsc_pkg::CH_NL) begin
            case (r_count)
                2'd0:    r_byte0 <= in_ch.rx_byte;
                2'd1:    r_byte1 <= in_ch.rx_byte;
                2'd2:    r_byte2 <= in_ch.rx_byte;
                default: r_byte2 <= r_byte2;
            endcase
        end
    end

endmodule

// ----- design/edsc_queue.sv -----
// Two-entry action queue between front and back end.
`timescale 1ns / 1ps

module edsc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  edsc_pkg::t_qitem i_push,
    output logic             o_ready,
    output edsc_pkg::t_qitem o_head,
    input  logic             i_pop
);

    localparam int DEPTH      = 2;
    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] FULL  = COUNT_BITS'(DEPTH);
    localparam logic [COUNT_BITS-1:0] C_ONE = COUNT_BITS'(1);
    localparam logic [PTR_BITS-1:0]   P_ONE = PTR_BITS'(1);

    edsc_pkg::t_action       r_entry [DEPTH];
    logic [PTR_BITS-1:0]     r_wr, r_rd;
    logic [COUNT_BITS-1:0]   r_count;

    assign o_ready       = r_count != FULL;
    assign o_head.valid  = r_count != '0;
    assign o_head.action = r_entry[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) r_wr <= r_wr + P_ONE;
            if (i_pop)        r_rd <= r_rd + P_ONE;
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + C_ONE;
                2'b01:   r_count <= r_count - C_ONE;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_entry[r_wr] <= i_push.action;
    end

endmodule

// ----- design/edsc_back.sv -----
// Back end: tick counters, drive states, straightness check and result register.
`timescale 1ns / 1ps

module edsc_back #(
    parameter int TICK_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [edsc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [edsc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  edsc_pkg::t_qitem                   i_head,
    output logic                               o_pop,
    edsc_out_if.source                         out_ch
);

    localparam int DIFF_BITS = TICK_BITS + 1;
    localparam logic signed [TICK_BITS-1:0] TICK_MAX = {1'b0, {(TICK_BITS-1){1'b1}}};
    localparam logic signed [TICK_BITS-1:0] TICK_MIN = {1'b1, {(TICK_BITS-1){1'b0}}};
    localparam logic signed [TICK_BITS-1:0] TICK_ONE = TICK_BITS'(1);
    localparam logic signed [DIFF_BITS-1:0] DIFF_ONE = DIFF_BITS'(1);

    logic signed [TICK_BITS-1:0] r_left, r_right, n_left, n_right;
    logic signed [DIFF_BITS-1:0] r_diff, n_diff, lr, act_w, rel_w;
    logic [1:0] r_mode, n_mode, r_side, n_side;
    logic [1:0] r_drv_l, r_drv_r, r_drv_c, n_drv_l, n_drv_r, n_drv_c;
    logic       r_moving, n_moving, r_corr, n_corr;
    logic       r_out_valid;
    logic [edsc_pkg::CFG_DATA_BITS-1:0] r_act, r_rel;
    logic [1:0] dir;

    assign o_pop = i_head.valid && (!r_out_valid || out_ch.ready);

    // r_diff tracks right minus left
    always_comb begin
        n_left   = r_left;
        n_right  = r_right;
        n_diff   = r_diff;
        n_mode   = r_mode;
        n_moving = r_moving;
        n_corr   = r_corr;
        n_side   = r_side;
        n_drv_l  = r_drv_l;
        n_drv_r  = r_drv_r;
        n_drv_c  = r_drv_c;
        case (i_head.action)
            edsc_pkg::ACT_LEFT_UP: begin
                if (r_left != TICK_MAX) begin
                    n_left = r_left + TICK_ONE;
                    n_diff = r_diff - DIFF_ONE;
                end
            end
            edsc_pkg::ACT_LEFT_DOWN: begin
                if (r_left != TICK_MIN) begin
                    n_left = r_left - TICK_ONE;
                    n_diff = r_diff + DIFF_ONE;
                end
            end
            edsc_pkg::ACT_RIGHT_UP: begin
                if (r_right != TICK_MAX) begin
                    n_right = r_right + TICK_ONE;
                    n_diff  = r_diff + DIFF_ONE;
                end
            end
            edsc_pkg::ACT_RIGHT_DOWN: begin
                if (r_right != TICK_MIN) begin
                    n_right = r_right - TICK_ONE;
                    n_diff  = r_diff - DIFF_ONE;
                end
            end
            edsc_pkg::ACT_GO_FWD: begin
                n_mode   = edsc_pkg::MODE_FWD;
                n_moving = 1'b1;
                n_drv_l  = edsc_pkg::DRV_FWD;
                n_drv_r  = edsc_pkg::DRV_FWD;
            end
            edsc_pkg::ACT_GO_BACK: begin
                n_mode   = edsc_pkg::MODE_BACK;
                n_moving = 1'b1;
                n_drv_l  = edsc_pkg::DRV_BACK;
                n_drv_r  = edsc_pkg::DRV_BACK;
            end
            edsc_pkg::ACT_LEFT_FWD:   n_drv_l = edsc_pkg::DRV_FWD;
            edsc_pkg::ACT_LEFT_BACK:  n_drv_l = edsc_pkg::DRV_BACK;
            edsc_pkg::ACT_RIGHT_FWD:  n_drv_r = edsc_pkg::DRV_FWD;
            edsc_pkg::ACT_RIGHT_BACK: n_drv_r = edsc_pkg::DRV_BACK;
            edsc_pkg::ACT_HALT: begin
                n_moving = 1'b0;
                n_drv_l  = edsc_pkg::DRV_OFF;
                n_drv_r  = edsc_pkg::DRV_OFF;
                n_drv_c  = edsc_pkg::CTR_OFF;
            end
            edsc_pkg::ACT_CTR_LEFT:  n_drv_c = edsc_pkg::CTR_LEFT;
            edsc_pkg::ACT_CTR_RIGHT: n_drv_c = edsc_pkg::CTR_RIGHT;
            edsc_pkg::ACT_ALL_OFF: begin
                n_drv_l = edsc_pkg::DRV_OFF;
                n_drv_r = edsc_pkg::DRV_OFF;
                n_drv_c = edsc_pkg::CTR_OFF;
            end
            default: begin
                n_drv_c = r_drv_c;
            end
        endcase

        lr    = -n_diff;
        act_w = $signed({{(DIFF_BITS-edsc_pkg::CFG_DATA_BITS){1'b0}}, r_act});
        rel_w = $signed({{(DIFF_BITS-edsc_pkg::CFG_DATA_BITS){1'b0}}, r_rel});
        dir   = (n_mode == edsc_pkg::MODE_FWD) ? edsc_pkg::DRV_FWD : edsc_pkg::DRV_BACK;

        if (n_moving && n_mode == edsc_pkg::MODE_FWD) begin
            if (n_diff > act_w) begin
                n_drv_r = edsc_pkg::DRV_OFF;
                n_side  = edsc_pkg::SIDE_RIGHT;
                n_corr  = 1'b1;
            end
            if (lr > act_w) begin
                n_drv_l = edsc_pkg::DRV_OFF;
                n_side  = edsc_pkg::SIDE_LEFT;
                n_corr  = 1'b1;
            end
            if (n_corr && ((n_side == edsc_pkg::SIDE_LEFT && lr < rel_w)
                        || (n_side == edsc_pkg::SIDE_RIGHT && n_diff < rel_w))) begin
                n_drv_l = dir;
                n_drv_r = dir;
                n_side  = edsc_pkg::SIDE_NONE;
                n_corr  = 1'b0;
            end
        end else if (n_moving && n_mode == edsc_pkg::MODE_BACK) begin
            if (n_diff > act_w) begin
                n_drv_l = edsc_pkg::DRV_OFF;
                n_side  = edsc_pkg::SIDE_LEFT;
                n_corr  = 1'b1;
            end
            if (lr > act_w) begin
                n_drv_r = edsc_pkg::DRV_OFF;
                n_side  = edsc_pkg::SIDE_RIGHT;
                n_corr  = 1'b1;
            end
            if (n_corr && ((n_side == edsc_pkg::SIDE_LEFT && n_diff < rel_w)
                        || (n_side == edsc_pkg::SIDE_RIGHT && lr < rel_w))) begin
                n_drv_l = dir;
                n_drv_r = dir;
                n_side  = edsc_pkg::SIDE_NONE;
                n_corr  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_right     <= '0;
            r_diff      <= '0;
            r_mode      <= edsc_pkg::MODE_STILL;
            r_moving    <= 1'b0;
            r_corr      <= 1'b0;
            r_side      <= edsc_pkg::SIDE_NONE;
            r_drv_l     <= edsc_pkg::DRV_OFF;
            r_drv_r     <= edsc_pkg::DRV_OFF;
            r_drv_c     <= edsc_pkg::CTR_OFF;
            r_out_valid <= 1'b0;
            r_act       <= edsc_pkg::ACTIVATE_RESET;
            r_rel       <= edsc_pkg::RELEASE_RESET;
        end else begin
            if (o_pop) begin
                r_left      <= n_left;
                r_right     <= n_right;
                r_diff      <= n_diff;
                r_mode      <= n_mode;
                r_moving    <= n_moving;
                r_corr      <= n_corr;
                r_side      <= n_side;
                r_drv_l     <= n_drv_l;
                r_drv_r     <= n_drv_r;
                r_drv_c     <= n_drv_c;
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == edsc_pkg::CFG_ACTIVATE) r_act <= i_cfg_data;
                if (i_cfg_index == edsc_pkg::CFG_RELEASE)  r_rel <= i_cfg_data;
            end
        end
    end

    // state only moves on a pop, so it holds as the result until transferred
    assign out_ch.valid          = r_out_valid;
    assign out_ch.left_drive     = r_drv_l;
    assign out_ch.right_drive    = r_drv_r;
    assign out_ch.center_drive   = r_drv_c;
    assign out_ch.correcting_now = r_corr;
    assign out_ch.side_stopped   = r_side;
    assign out_ch.left_count     = r_left;
    assign out_ch.right_count    = r_right;

endmodule
